// ===== hdl/palette_blinker_table_assert.svh =====
// assertion helpers shared by the blinker table modules
// both expect clk and rst_n in scope
`ifndef PALETTE_BLINKER_TABLE_ASSERT_SVH
`define PALETTE_BLINKER_TABLE_ASSERT_SVH

// same-cycle implication
`define PBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbt_pkg;

  localparam int NUM_LIGHTS_DEF = 32;
  localparam int TICK_BITS_DEF  = 16;

  // width that holds any slot number and the table depth itself
  localparam int SLOT_EXT_W = 9;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_ACTIVE = 2'd1;
  localparam logic [1:0] STAT_FULL       = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  slot;
    logic [7:0]  palette_index;
    logic [31:0] lit_color;
    logic [31:0] dark_color;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [4:0]  slot_out;
    logic [7:0]  target_index;
    logic [31:0] write_color;
    logic        last;
  } out_word_t;

  // per-slot settings kept in memory
  typedef struct packed {
    logic [7:0]  target;
    logic [31:0] lit_color;
    logic [31:0] dark_color;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
  } light_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_CHECK,
    ST_UPD_WR,
    ST_TICK,
    ST_TICK_END,
    ST_STATUS
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_IDX,
    SRC_SLOT
  } stat_src_t;

  typedef struct packed {
    logic       latch;
    logic       mem_rd;
    logic       sel_slot;
    logic       tick_issue;
    logic       add_commit;
    logic       del_commit;
    logic       upd_commit;
    logic       emit_status;
    logic [1:0] stat_code;
    stat_src_t  stat_src;
  } pbt_cmd_t;

  typedef struct packed {
    logic idx_free;
    logic slot_ok;
  } pbt_sts_t;

endpackage

`default_nettype wire

// ===== hdl/pbt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "palette_blinker_table_assert.svh"

module pbt_ctrl #(
  parameter int NUM_LIGHTS = pbt_pkg::NUM_LIGHTS_DEF,
  parameter int IDX_W      = 5
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire  [1:0]            in_mode,
  input  pbt_pkg::pbt_sts_t     sts,
  output logic                  busy,
  output pbt_pkg::pbt_cmd_t     cmd,
  output logic [IDX_W-1:0]      idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LIGHTS - 1);

  pbt_pkg::state_t    state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [1:0]         stat_code_r, stat_code_nxt;
  pbt_pkg::stat_src_t stat_src_r, stat_src_nxt;
  logic               last_slot;

  assign last_slot = (idx_r == LAST_IDX);
  assign idx       = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbt_pkg::ST_IDLE;
      idx_r       <= '0;
      mode_r      <= pbt_pkg::MODE_ADD;
      stat_code_r <= pbt_pkg::STAT_OK;
      stat_src_r  <= pbt_pkg::SRC_ZERO;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      mode_r      <= mode_nxt;
      stat_code_r <= stat_code_nxt;
      stat_src_r  <= stat_src_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    mode_nxt      = mode_r;
    stat_code_nxt = stat_code_r;
    stat_src_nxt  = stat_src_r;
    unique case (state_r)
      pbt_pkg::ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          idx_nxt  = '0;
          unique case (in_mode)
            pbt_pkg::MODE_ADD: begin
              state_nxt = pbt_pkg::ST_ADD_SCAN;
            end
            pbt_pkg::MODE_TICK: begin
              state_nxt     = pbt_pkg::ST_TICK;
              stat_code_nxt = pbt_pkg::STAT_OK;
              stat_src_nxt  = pbt_pkg::SRC_ZERO;
            end
            default: begin
              state_nxt = pbt_pkg::ST_CHECK;
            end
          endcase
        end
      end
      pbt_pkg::ST_ADD_SCAN: begin
        priority if (sts.idx_free) begin
          state_nxt     = pbt_pkg::ST_STATUS;
          stat_code_nxt = pbt_pkg::STAT_OK;
          stat_src_nxt  = pbt_pkg::SRC_IDX;
        end else if (last_slot) begin
          state_nxt     = pbt_pkg::ST_STATUS;
          stat_code_nxt = pbt_pkg::STAT_FULL;
          stat_src_nxt  = pbt_pkg::SRC_ZERO;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      pbt_pkg::ST_CHECK: begin
        priority if (!sts.slot_ok) begin
          state_nxt     = pbt_pkg::ST_STATUS;
          stat_code_nxt = pbt_pkg::STAT_NOT_ACTIVE;
          stat_src_nxt  = pbt_pkg::SRC_SLOT;
        end else if (mode_r == pbt_pkg::MODE_DELETE) begin
          state_nxt     = pbt_pkg::ST_STATUS;
          stat_code_nxt = pbt_pkg::STAT_OK;
          stat_src_nxt  = pbt_pkg::SRC_SLOT;
        end else begin
          state_nxt = pbt_pkg::ST_UPD_WR;
        end
      end
      pbt_pkg::ST_UPD_WR: begin
        state_nxt     = pbt_pkg::ST_STATUS;
        stat_code_nxt = pbt_pkg::STAT_OK;
        stat_src_nxt  = pbt_pkg::SRC_SLOT;
      end
      pbt_pkg::ST_TICK: begin
        if (last_slot) begin
          state_nxt = pbt_pkg::ST_TICK_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      pbt_pkg::ST_TICK_END: begin
        // last slot is finished in the datapath this cycle
        state_nxt = pbt_pkg::ST_STATUS;
      end
      pbt_pkg::ST_STATUS: begin
        state_nxt = pbt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.stat_code = stat_code_r;
    cmd.stat_src  = stat_src_r;
    busy          = (state_r != pbt_pkg::ST_IDLE);
    unique case (state_r)
      pbt_pkg::ST_IDLE: begin
        cmd.latch = start;
      end
      pbt_pkg::ST_ADD_SCAN: begin
        cmd.add_commit = sts.idx_free;
      end
      pbt_pkg::ST_CHECK: begin
        cmd.mem_rd     = 1'b1;
        cmd.sel_slot   = 1'b1;
        cmd.del_commit = sts.slot_ok && (mode_r == pbt_pkg::MODE_DELETE);
      end
      pbt_pkg::ST_UPD_WR: begin
        cmd.upd_commit = 1'b1;
      end
      pbt_pkg::ST_TICK: begin
        cmd.mem_rd     = 1'b1;
        cmd.tick_issue = 1'b1;
      end
      pbt_pkg::ST_STATUS: begin
        cmd.emit_status = 1'b1;
      end
      default: begin
        cmd.latch = 1'b0;
      end
    endcase
  end

  `PBT_ASSERT_IMP(a_idx_in_range, state_r != pbt_pkg::ST_IDLE,
    pbt_pkg::SLOT_EXT_W'(idx_r) < pbt_pkg::SLOT_EXT_W'(NUM_LIGHTS), "slot index past table")
  `PBT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `PBT_ASSERT_NEXT(a_tick_drain, state_r == pbt_pkg::ST_TICK && last_slot,
    state_r == pbt_pkg::ST_TICK_END, "tick walk did not drain after last slot")

endmodule

`default_nettype wire

// ===== hdl/pbt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "palette_blinker_table_assert.svh"

module pbt_datapath #(
  parameter int NUM_LIGHTS = pbt_pkg::NUM_LIGHTS_DEF,
  parameter int TICK_BITS  = pbt_pkg::TICK_BITS_DEF,
  parameter int IDX_W      = 5
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  pbt_pkg::pbt_cmd_t     cmd,
  input  wire  [IDX_W-1:0]      idx,
  input  pbt_pkg::in_word_t     in_data,
  output pbt_pkg::pbt_sts_t     sts,
  output logic                  out_valid,
  output pbt_pkg::out_word_t    out_data
);

  localparam int CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;
  localparam int SEW   = pbt_pkg::SLOT_EXT_W;

  pbt_pkg::in_word_t   in_r;
  logic [NUM_LIGHTS-1:0] active_r, active_nxt;
  logic [NUM_LIGHTS-1:0] phase_r, phase_nxt;

  pbt_pkg::light_t     light_mem [NUM_LIGHTS];
  logic [TICK_BITS-1:0] cnt_mem [NUM_LIGHTS];
  pbt_pkg::light_t     light_q;
  logic [TICK_BITS-1:0] cnt_q;

  logic                p_valid_r;
  logic [IDX_W-1:0]    p_slot_r;

  logic [SEW-1:0]      slot_ext, idx_ext, p_slot_ext;
  logic [IDX_W-1:0]    slot_idx, rd_addr;
  logic                in_range;

  logic                cur_phase, flip;
  logic [TICK_BITS-1:0] cnt_inc;
  logic [15:0]         limit;

  logic                light_we, cnt_we;
  logic [IDX_W-1:0]    light_wa, cnt_wa;
  pbt_pkg::light_t     light_wd;
  logic [TICK_BITS-1:0] cnt_wd;

  logic                out_valid_r, out_valid_nxt;
  pbt_pkg::out_word_t  out_r, out_nxt;
  logic [3:0]          emit_vec;

  assign slot_ext   = SEW'(in_r.slot);
  assign idx_ext    = SEW'(idx);
  assign p_slot_ext = SEW'(p_slot_r);
  assign slot_idx   = slot_ext[IDX_W-1:0];
  assign in_range   = (slot_ext < SEW'(NUM_LIGHTS));
  assign rd_addr    = cmd.sel_slot ? slot_idx : idx;

  assign sts.idx_free = !active_r[idx];
  assign sts.slot_ok  = in_range && active_r[slot_idx];

  // counter step of the light read in the previous cycle
  assign cur_phase = phase_r[p_slot_r];
  assign cnt_inc   = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
  assign limit     = cur_phase ? light_q.on_ticks : light_q.off_ticks;
  assign flip      = (CMP_W'(cnt_inc) >= CMP_W'(limit));

  always_comb begin
    light_we = 1'b0;
    light_wa = idx;
    light_wd = light_q;
    cnt_we   = 1'b0;
    cnt_wa   = idx;
    cnt_wd   = '0;
    if (cmd.add_commit) begin
      light_we            = 1'b1;
      light_wd.target     = in_r.palette_index;
      light_wd.lit_color  = in_r.lit_color;
      light_wd.dark_color = in_r.dark_color;
      light_wd.on_ticks   = in_r.on_ticks;
      light_wd.off_ticks  = in_r.off_ticks;
      cnt_we              = 1'b1;
    end else if (cmd.upd_commit) begin
      // target comes back from the read done during the slot check
      light_we            = 1'b1;
      light_wa            = slot_idx;
      light_wd.lit_color  = in_r.lit_color;
      light_wd.dark_color = in_r.dark_color;
      light_wd.on_ticks   = in_r.on_ticks;
      light_wd.off_ticks  = in_r.off_ticks;
    end else if (p_valid_r) begin
      cnt_we = 1'b1;
      cnt_wa = p_slot_r;
      cnt_wd = flip ? '0 : cnt_inc;
    end
  end

  always_comb begin
    active_nxt = active_r;
    phase_nxt  = phase_r;
    if (cmd.add_commit) begin
      active_nxt[idx] = 1'b1;
      phase_nxt[idx]  = 1'b0;
    end
    if (cmd.del_commit) begin
      active_nxt[slot_idx] = 1'b0;
      phase_nxt[slot_idx]  = 1'b0;
    end
    if (p_valid_r && flip) begin
      phase_nxt[p_slot_r] = !cur_phase;
    end
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    priority if (cmd.add_commit) begin
      out_valid_nxt        = 1'b1;
      out_nxt.kind         = pbt_pkg::KIND_WRITE;
      out_nxt.status       = pbt_pkg::STAT_OK;
      out_nxt.slot_out     = idx_ext[4:0];
      out_nxt.target_index = in_r.palette_index;
      out_nxt.write_color  = in_r.dark_color;
    end else if (cmd.upd_commit) begin
      out_valid_nxt        = 1'b1;
      out_nxt.kind         = pbt_pkg::KIND_WRITE;
      out_nxt.status       = pbt_pkg::STAT_OK;
      out_nxt.slot_out     = in_r.slot;
      out_nxt.target_index = light_q.target;
      out_nxt.write_color  = phase_r[slot_idx] ? in_r.lit_color : in_r.dark_color;
    end else if (p_valid_r && flip) begin
      out_valid_nxt        = 1'b1;
      out_nxt.kind         = pbt_pkg::KIND_WRITE;
      out_nxt.status       = pbt_pkg::STAT_OK;
      out_nxt.slot_out     = p_slot_ext[4:0];
      out_nxt.target_index = light_q.target;
      // color of the phase being entered
      out_nxt.write_color  = cur_phase ? light_q.dark_color : light_q.lit_color;
    end else if (cmd.emit_status) begin
      out_valid_nxt  = 1'b1;
      out_nxt.kind   = pbt_pkg::KIND_STATUS;
      out_nxt.status = cmd.stat_code;
      out_nxt.last   = 1'b1;
      unique case (cmd.stat_src)
        pbt_pkg::SRC_IDX:  out_nxt.slot_out = idx_ext[4:0];
        pbt_pkg::SRC_SLOT: out_nxt.slot_out = in_r.slot;
        default:           out_nxt.slot_out = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      phase_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      p_valid_r   <= cmd.tick_issue && active_r[idx];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r <= in_data;
    end
    if (cmd.tick_issue) begin
      p_slot_r <= idx;
    end
    out_r <= out_nxt;
  end

  // slot settings and counters, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (light_we) begin
      light_mem[light_wa] <= light_wd;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd.mem_rd) begin
      light_q <= light_mem[rd_addr];
      cnt_q   <= cnt_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign emit_vec  = {cmd.add_commit, cmd.upd_commit, p_valid_r, cmd.emit_status};

  `PBT_ASSERT_IMP(a_one_source, 1'b1, $onehot0(emit_vec), "two word sources in one cycle")
  `PBT_ASSERT_IMP(a_tick_active, p_valid_r, active_r[p_slot_r], "tick step on an idle slot")
  `PBT_ASSERT_NEXT(a_add_sets_slot, cmd.add_commit,
    active_r[$past(idx)] && !phase_r[$past(idx)], "added light not active in off phase")

endmodule

`default_nettype wire

// ===== hdl/palette_blinker_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Table of blinking palette lights.
// Input: a command word (add, delete, update, tick) on in_data is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// command is done; the next command may be given in the cycle busy is low.
// Output: every word is shown on out_data for one cycle with out_valid high.
// Palette write words (kind 1) come first, then one status word marked last.
// The receiver cannot stall; it must take each word in its cycle.
// The add's first-free search walks one slot a cycle; a tick visits one slot
// a cycle through the slot memory, read and write-back overlapped. The status
// word is on out_data in the first cycle with busy low.
// Reset (rst_n low, synchronous) marks every slot free at once; slot memory
// contents need no clearing since a slot is always fully written when added.

module palette_blinker_table #(
  parameter int NUM_LIGHTS = pbt_pkg::NUM_LIGHTS_DEF,
  parameter int TICK_BITS  = pbt_pkg::TICK_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  pbt_pkg::in_word_t   in_data,
  output logic                out_valid,
  output pbt_pkg::out_word_t  out_data
);

  localparam int IDX_W = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;

  pbt_pkg::pbt_cmd_t cmd;
  pbt_pkg::pbt_sts_t sts;
  logic [IDX_W-1:0]  idx;

  pbt_ctrl #(
    .NUM_LIGHTS (NUM_LIGHTS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_data.mode),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd),
    .idx     (idx)
  );

  pbt_datapath #(
    .NUM_LIGHTS (NUM_LIGHTS),
    .TICK_BITS  (TICK_BITS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .idx       (idx),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
